[rtl/cda_pkg.sv]
`timescale 1ns / 1ps

package cda_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int DELTA_W = 16;
	localparam int YACC_W  = 16;
	localparam int DACC_W  = 17;

	localparam logic [MONTH_W-1:0] M_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] M_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] M_APR = 4'd4;
	localparam logic [MONTH_W-1:0] M_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] M_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] M_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] M_DEC = 4'd12;

	localparam logic signed [YACC_W-1:0] YEAR_MAX = 16'sd9999;

	typedef struct packed {
		logic signed [YACC_W-1:0] year;
		logic [MONTH_W-1:0]       month;
		logic signed [DACC_W-1:0] day;
	} cda_date_t;

	typedef struct packed {
		cda_date_t nxt;
		logic      fin;
	} cda_step_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [1:0] year_lsb,
			input logic [MONTH_W-1:0] month);
		logic [DAY_W-1:0] len;
		unique case (month)
			M_FEB: len = (year_lsb == 2'd0) ? 5'd29 : 5'd28;
			M_APR, M_JUN, M_SEP, M_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

[rtl/cda_in_if.sv]
`timescale 1ns / 1ps

interface cda_in_if;
	logic        valid;
	logic        ready;
	logic [13:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic signed [15:0] days_delta;

	modport source (output valid, year, month, day, days_delta, input ready);
	modport sink   (input valid, year, month, day, days_delta, output ready);
endinterface

[rtl/cda_out_if.sv]
`timescale 1ns / 1ps

interface cda_out_if;
	logic        valid;
	logic        ready;
	logic [13:0] result_year;
	logic [3:0]  result_month;
	logic [4:0]  result_day;
	logic        out_of_range;

	modport source (output valid, result_year, result_month, result_day, out_of_range,
		input ready);
	modport sink   (input valid, result_year, result_month, result_day, out_of_range,
		output ready);
endinterface

[rtl/calendar_date_add_days.sv]
`timescale 1ns / 1ps

// Calendar date adder, Julian leap rule (every fourth year).
// Input channel din carries one date (year, month, day) and a signed day
// offset per beat; output channel dout carries one result beat per input:
// the shifted date and out_of_range. When the result year leaves 0..9999,
// or the input month is not 1..12, out_of_range is set and the input date
// is echoed.
// The date is normalized one calendar month per cycle by a single shared
// add/compare unit. An accepted item is stepped once per month boundary
// crossed (0 to about 1080 for the full offset range), and then its
// result is written to the output register.
// din.ready is high only while no item is in work, one item at a time.
// A finished result sits in an output register; a new item may be taken
// while it waits. If dout stalls, the next result holds in the sequencer
// until the register frees, and din stays low meanwhile.
// arst_n clears the sequencer state and the output valid; the data registers are not reset.
module calendar_date_add_days
	import cda_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cda_in_if.sink      din,
	cda_out_if.source   dout
);

	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_RUN  = 1'b1;

	logic [0:0]         state_q;
	cda_date_t          cur_q;
	logic               back_q;
	logic [YEAR_W-1:0]  yin_q;
	logic [MONTH_W-1:0] min_q;
	logic [DAY_W-1:0]   din_q;
	logic               out_valid_q;
	logic [YEAR_W-1:0]  res_year_q;
	logic [MONTH_W-1:0] res_month_q;
	logic [DAY_W-1:0]   res_day_q;
	logic               res_oor_q;

	cda_step_t          step;
	logic               accept;
	logic               mvalid;
	logic               fin_now;
	logic               out_free;
	logic               load_out;
	logic               bad;
	logic signed [DACC_W-1:0] start_day;

	cda_step u_step (
		.cur  (cur_q),
		.back (back_q),
		.res  (step)
	);

	assign accept    = din.valid && din.ready;
	assign start_day = $signed({{(DACC_W-DAY_W){1'b0}}, din.day})
		+ $signed({din.days_delta[DELTA_W-1], din.days_delta});
	assign mvalid    = (min_q >= M_JAN) && (min_q <= M_DEC);
	assign fin_now   = !mvalid || step.fin;
	assign out_free  = !out_valid_q || dout.ready;
	assign load_out  = (state_q == ST_RUN) && fin_now && out_free;
	assign bad       = !mvalid || (cur_q.year < 16'sd0) || (cur_q.year > YEAR_MAX);

	assign din.ready         = (state_q == ST_IDLE);
	assign dout.valid        = out_valid_q;
	assign dout.result_year  = res_year_q;
	assign dout.result_month = res_month_q;
	assign dout.result_day   = res_day_q;
	assign dout.out_of_range = res_oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_RUN;
				ST_RUN:  if (load_out) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q.year  <= {{(YACC_W-YEAR_W){1'b0}}, din.year};
			cur_q.month <= din.month;
			cur_q.day   <= start_day;
			back_q      <= (start_day < 17'sd1);
			yin_q       <= din.year;
			min_q       <= din.month;
			din_q       <= din.day;
		end else if (state_q == ST_RUN && !fin_now) begin
			cur_q <= step.nxt;
		end
		if (load_out) begin
			if (bad) begin
				res_year_q  <= yin_q;
				res_month_q <= min_q;
				res_day_q   <= din_q;
				res_oor_q   <= 1'b1;
			end else begin
				res_year_q  <= cur_q.year[YEAR_W-1:0];
				res_month_q <= cur_q.month;
				res_day_q   <= cur_q.day[DAY_W-1:0];
				res_oor_q   <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN))
		else $error("accepted beat did not start work");

	a_month_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && !dout.out_of_range) |->
			(dout.result_month >= M_JAN && dout.result_month <= M_DEC))
		else $error("result month out of range");

	a_day_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && !dout.out_of_range) |->
			(dout.result_day != 5'd0 && dout.result_day <= month_len(
				dout.result_year[1:0], dout.result_month)))
		else $error("result day invalid for its month");

	a_year_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && !dout.out_of_range) |-> (dout.result_year <= 14'd9999))
		else $error("result year above limit without out_of_range");

	a_run_month: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && mvalid) |-> (cur_q.month >= M_JAN && cur_q.month <= M_DEC))
		else $error("month register left 1..12 during stepping");
`endif

endmodule

[rtl/cda_step.sv]
`timescale 1ns / 1ps

module cda_step
	import cda_pkg::*;
(
	input  cda_date_t cur,
	input  logic      back,
	output cda_step_t res
);

	logic [DAY_W-1:0]         len_fwd;
	logic [DAY_W-1:0]         len_bwd;
	logic [MONTH_W-1:0]       m_prev;
	logic [MONTH_W-1:0]       m_next;
	logic signed [YACC_W-1:0] y_prev;
	logic signed [YACC_W-1:0] y_next;
	logic signed [DACC_W-1:0] len_f_ext;
	logic signed [DACC_W-1:0] len_b_ext;
	logic signed [DACC_W-1:0] addend;
	logic signed [DACC_W-1:0] sum;

	always_comb begin
		m_prev = (cur.month == M_JAN) ? M_DEC : cur.month - 4'd1;
		y_prev = (cur.month == M_JAN) ? cur.year - 16'sd1 : cur.year;
		m_next = (cur.month == M_DEC) ? M_JAN : cur.month + 4'd1;
		y_next = (cur.month == M_DEC) ? cur.year + 16'sd1 : cur.year;

		len_fwd = month_len(cur.year[1:0], cur.month);
		len_bwd = month_len(y_prev[1:0], m_prev);
		len_f_ext = {{(DACC_W-DAY_W){1'b0}}, len_fwd};
		len_b_ext = {{(DACC_W-DAY_W){1'b0}}, len_bwd};

		// single shared adder: add previous length going back, subtract current going forward
		addend = back ? len_b_ext : -len_f_ext;
		sum    = cur.day + addend;

		if (back) begin
			res.fin       = (cur.day >= 17'sd1);
			res.nxt.year  = y_prev;
			res.nxt.month = m_prev;
		end else begin
			res.fin       = (cur.day <= len_f_ext);
			res.nxt.year  = y_next;
			res.nxt.month = m_next;
		end
		res.nxt.day = sum;
	end

endmodule

[test/calendar_date_add_days_test.sv]
`timescale 1ns / 1ps

module calendar_date_add_days_test;
	import cda_pkg::*;

	localparam int STALL_LIMIT = 10000;
	localparam int HOLD_CYCLES = 500;
	localparam int RANDOM_ITEMS = 520;

	typedef struct packed {
		logic [YEAR_W-1:0]         year;
		logic [MONTH_W-1:0]        month;
		logic [DAY_W-1:0]          day;
		logic signed [DELTA_W-1:0] days_delta;
	} date_in_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic               out_of_range;
	} date_out_t;

	class date_scoreboard;
		date_out_t expected_dates[$];
		int fails;
		int checked;

		static function int days_in(int y, int m);
			if (m == int'(M_FEB))
				return ((y & 3) == 0) ? 29 : 28;
			if (m == int'(M_APR) || m == int'(M_JUN) || m == int'(M_SEP) || m == int'(M_NOV))
				return 30;
			return 31;
		endfunction

		static function date_out_t shift_date(date_in_t b);
			int y;
			int m;
			int d;
			bit bad;
			date_out_t r;
			y = int'(b.year);
			m = int'(b.month);
			d = 0;
			bad = 0;
			if (m < int'(M_JAN) || m > int'(M_DEC)) begin
				bad = 1;
			end else begin
				d = int'(b.day) + int'($signed(b.days_delta));
				if (d >= 1) begin
					while (d > days_in(y, m)) begin
						d -= days_in(y, m);
						m++;
						if (m > int'(M_DEC)) begin
							m = int'(M_JAN);
							y++;
						end
					end
				end else begin
					while (d < 1) begin
						m--;
						if (m < int'(M_JAN)) begin
							m = int'(M_DEC);
							y--;
						end
						d += days_in(y, m);
					end
				end
				if (y < 0 || y > int'(YEAR_MAX))
					bad = 1;
			end
			if (bad) begin
				r.year = b.year;
				r.month = b.month;
				r.day = b.day;
				r.out_of_range = 1'b1;
			end else begin
				r.year = y[YEAR_W-1:0];
				r.month = m[MONTH_W-1:0];
				r.day = d[DAY_W-1:0];
				r.out_of_range = 1'b0;
			end
			return r;
		endfunction

		function void note_input(date_in_t b);
			expected_dates.push_back(shift_date(b));
		endfunction

		function void check_result(date_out_t got);
			date_out_t want;
			bit bad;
			checked++;
			if (expected_dates.size() == 0) begin
				$error("unexpected result beat: %0d-%0d-%0d oor=%0d",
					got.year, got.month, got.day, got.out_of_range);
				fails++;
				return;
			end
			want = expected_dates.pop_front();
			bad = 0;
			if (got.year !== want.year) begin
				$error("result_year: expected %0d, got %0d", want.year, got.year);
				bad = 1;
			end
			if (got.month !== want.month) begin
				$error("result_month: expected %0d, got %0d", want.month, got.month);
				bad = 1;
			end
			if (got.day !== want.day) begin
				$error("result_day: expected %0d, got %0d", want.day, got.day);
				bad = 1;
			end
			if (got.out_of_range !== want.out_of_range) begin
				$error("out_of_range: expected %0d, got %0d", want.out_of_range,
					got.out_of_range);
				bad = 1;
			end
			if (bad)
				fails++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit send_steady;
	date_scoreboard sb;

	cda_in_if  din_if();
	cda_out_if dout_if();

	calendar_date_add_days dut (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_if),
		.dout(dout_if)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic date_in_t make_beat(int y, int m, int d, int delta);
		date_in_t b;
		b.year = y[YEAR_W-1:0];
		b.month = m[MONTH_W-1:0];
		b.day = d[DAY_W-1:0];
		b.days_delta = delta[DELTA_W-1:0];
		return b;
	endfunction

	task automatic send_beat(input date_in_t b);
		if (!send_steady && $urandom_range(99) < 24) begin
			din_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.year <= b.year;
		din_if.month <= b.month;
		din_if.day <= b.day;
		din_if.days_delta <= b.days_delta;
		@(posedge clk);
		while (!din_if.ready)
			@(posedge clk);
		sb.note_input(b);
	endtask

	// receiver: random stalls, one long hold-off to back up the block
	initial begin
		bit rdy;
		bit held;
		held = 0;
		dout_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && sb.checked >= 80) begin
				held = 1;
				dout_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rdy = (sb.checked >= 250 && sb.checked < 400) || $urandom_range(99) >= 24;
			dout_if.ready <= rdy;
			@(posedge clk);
			if (dout_if.valid && dout_if.ready)
				sb.check_result({dout_if.result_year, dout_if.result_month,
					dout_if.result_day, dout_if.out_of_range});
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (arst_n && !(din_if.valid && din_if.ready) && !(dout_if.valid && dout_if.ready))
				quiet++;
			else
				quiet = 0;
			if (quiet >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		date_in_t b;
		int y;
		int m;
		int pick;
		int delta;
		sb = new();
		send_steady = 0;
		arst_n <= 1'b0;
		din_if.valid <= 1'b0;
		din_if.year <= '0;
		din_if.month <= '0;
		din_if.day <= '0;
		din_if.days_delta <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(make_beat(2024, 1, 1, 0));
		send_beat(make_beat(0, 1, 1, -1));
		send_beat(make_beat(9999, 12, 31, 1));
		send_beat(make_beat(9999, 12, 31, 0));
		send_beat(make_beat(0, 1, 1, 32767));
		send_beat(make_beat(9999, 12, 31, -32768));
		send_beat(make_beat(9950, 6, 15, 32767));
		send_beat(make_beat(16383, 12, 31, 0));
		send_beat(make_beat(10050, 1, 1, -32768));
		send_beat(make_beat(2000, 0, 15, 10));
		send_beat(make_beat(2000, 13, 15, 10));
		send_beat(make_beat(16383, 15, 31, -1));
		send_beat(make_beat(2023, 3, 0, 0));
		send_beat(make_beat(2023, 2, 31, 0));
		send_beat(make_beat(2023, 4, 31, 0));
		send_beat(make_beat(2023, 1, 0, -32768));
		send_beat(make_beat(2024, 2, 28, 1));
		send_beat(make_beat(2023, 2, 28, 1));
		send_beat(make_beat(2024, 3, 1, -1));
		send_beat(make_beat(1900, 2, 28, 1));
		send_beat(make_beat(2023, 12, 31, 1));
		send_beat(make_beat(2024, 1, 1, -1));
		send_beat(make_beat(5000, 12, 31, -32768));
		send_beat(make_beat(5000, 7, 31, 32767));

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			send_steady = (i >= 60 && i < 200);
			pick = $urandom_range(99);
			if (pick < 85) begin
				if ($urandom_range(9) == 0)
					y = ($urandom_range(1) != 0) ? $urandom_range(9900, 9999) : $urandom_range(100);
				else
					y = $urandom_range(9999);
				m = $urandom_range(1, 12);
				b = make_beat(y, m, $urandom_range(1, date_scoreboard::days_in(y, m)), 0);
			end else begin
				b = make_beat($urandom_range(16383), $urandom_range(15), $urandom_range(31), 0);
			end
			pick = $urandom_range(99);
			if (pick < 60)
				delta = $urandom_range(800) - 400;
			else if (pick < 85)
				delta = $urandom_range(8000) - 4000;
			else
				delta = $urandom;
			b.days_delta = delta[DELTA_W-1:0];
			send_beat(b);
		end
		send_steady = 0;
		din_if.valid <= 1'b0;

		while (sb.expected_dates.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
